// File: design/lvn_pkg.sv
// ----------------------------------------------------------------------------
// lvn_pkg
// shared constants and helpers for the lattice value noise pipeline
// ----------------------------------------------------------------------------
package lvn_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_W = 32;
	localparam int VAL_W = 16;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SEED = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THREE_DIMS = 8'd1;

	localparam logic [31:0] PRIME_A = 32'd374761393;
	localparam logic [31:0] PRIME_B = 32'd668265263;
	localparam logic [31:0] PRIME_C = 32'd1274126177;

	localparam int N_CORNERS = 8;

	// hash tail: scale to 16 bits
	function automatic logic [VAL_W-1:0] hash_tail(input logic [31:0] m);
		logic [31:0] h;
		h = m ^ (m >> 16);
		return h[30:15];
	endfunction

endpackage

// File: design/lattice_value_noise.sv
// ----------------------------------------------------------------------------
// lattice_value_noise
// start travels through the stage valid registers to done; one word accepted every cycle
// throughput limited by nothing: every stage is a plain pipeline register
// busy is tied low; results cannot be stalled by the receiver
// reset clears the valid bits and the seed and mode registers
// ----------------------------------------------------------------------------
module lattice_value_noise #(
	parameter int FRAC_BITS = lvn_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [lvn_pkg::COORD_W-1:0] coord_x,
	input  logic signed [lvn_pkg::COORD_W-1:0] coord_y,
	input  logic signed [lvn_pkg::COORD_W-1:0] coord_z,
	output logic                            done,
	output logic [lvn_pkg::VAL_W-1:0]       noise_value,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lvn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data
);

	localparam int FD = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int FU = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

	logic [31:0] seed_q;
	logic        three_dims_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			three_dims_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lvn_pkg::REG_SEED: seed_q <= cfg_data;
				lvn_pkg::REG_THREE_DIMS: three_dims_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	function automatic logic [15:0] frac_of(input logic [31:0] u);
		logic [31:0] t;
		t = ((u & ((32'd1 << FRAC_BITS) - 32'd1)) >> FD) << FU;
		return t[15:0];
	endfunction

	// ---- stage 1: cell index and fractional offset
	logic        v_s1, d3_s1;
	logic [31:0] ix_s1, iy_s1, iz_s1;
	logic [15:0] tx_s1, ty_s1, tz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		d3_s1 <= three_dims_q;
		ix_s1 <= 32'(coord_x >>> FRAC_BITS);
		iy_s1 <= 32'(coord_y >>> FRAC_BITS);
		iz_s1 <= 32'(coord_z >>> FRAC_BITS);
		tx_s1 <= frac_of(coord_x);
		ty_s1 <= frac_of(coord_y);
		tz_s1 <= frac_of(coord_z);
	end

	// ---- stage 2: lattice products (x, x+1, ...) and t squared
	logic        v_s2, d3_s2;
	logic [31:0] px_s2 [2];
	logic [31:0] py_s2 [2];
	logic [31:0] pz_s2 [2];
	logic [15:0] tx_s2, ty_s2, tz_s2;
	logic [31:0] sqx_s2, sqy_s2, sqz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		d3_s2 <= d3_s1;
		px_s2[0] <= ix_s1 * lvn_pkg::PRIME_A;
		px_s2[1] <= (ix_s1 + 32'd1) * lvn_pkg::PRIME_A;
		py_s2[0] <= iy_s1 * lvn_pkg::PRIME_B;
		py_s2[1] <= (iy_s1 + 32'd1) * lvn_pkg::PRIME_B;
		pz_s2[0] <= iz_s1 * lvn_pkg::PRIME_C;
		pz_s2[1] <= (iz_s1 + 32'd1) * lvn_pkg::PRIME_C;
		tx_s2 <= tx_s1;
		ty_s2 <= ty_s1;
		tz_s2 <= tz_s1;
		sqx_s2 <= tx_s1 * tx_s1;
		sqy_s2 <= ty_s1 * ty_s1;
		sqz_s2 <= tz_s1 * tz_s1;
	end

	// ---- stage 3: mixed corner words; fade products
	logic        v_s3, d3_s3;
	logic [31:0] mix_s3 [lvn_pkg::N_CORNERS];
	logic [15:0] sx_s3, sy_s3, sz_s3;

	function automatic logic [15:0] fade(input logic [31:0] sq, input logic [15:0] t);
		logic [49:0] p;
		p = 50'(sq) * (50'd196608 - 50'({t, 1'b0}));
		return p[47:32];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		logic [31:0] h;
		d3_s3 <= d3_s2;
		for (int c = 0; c < lvn_pkg::N_CORNERS; c++) begin
			h = seed_q ^ px_s2[c & 1] ^ py_s2[(c >> 1) & 1];
			if (d3_s2) h = h ^ pz_s2[(c >> 2) & 1];
			mix_s3[c] <= h ^ (h >> 13);
		end
		sx_s3 <= fade(sqx_s2, tx_s2);
		sy_s3 <= fade(sqy_s2, ty_s2);
		sz_s3 <= fade(sqz_s2, tz_s2);
	end

	// ---- stage 4: final hash multiply
	logic        v_s4, d3_s4;
	logic [31:0] mul_s4 [lvn_pkg::N_CORNERS];
	logic [15:0] sx_s4, sy_s4, sz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		d3_s4 <= d3_s3;
		for (int c = 0; c < lvn_pkg::N_CORNERS; c++)
			mul_s4[c] <= mix_s3[c] * (d3_s3 ? lvn_pkg::PRIME_A : lvn_pkg::PRIME_C);
		sx_s4 <= sx_s3;
		sy_s4 <= sy_s3;
		sz_s4 <= sz_s3;
	end

	// ---- stage 5: corner values
	logic        v_s5, d3_s5;
	logic [15:0] cv_s5 [lvn_pkg::N_CORNERS];
	logic [15:0] sx_s5, sy_s5, sz_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		d3_s5 <= d3_s4;
		for (int c = 0; c < lvn_pkg::N_CORNERS; c++)
			cv_s5[c] <= lvn_pkg::hash_tail(mul_s4[c]);
		sx_s5 <= sx_s4;
		sy_s5 <= sy_s4;
		sz_s5 <= sz_s4;
	end

	function automatic logic [15:0] lerp(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] s);
		logic [33:0] v;
		v = 34'(a) * (34'd65536 - 34'(s)) + 34'(b) * 34'(s);
		return v[31:16];
	endfunction

	// ---- stage 6: blend along x
	logic        v_s6, d3_s6;
	logic [15:0] bx_s6 [4];
	logic [15:0] sy_s6, sz_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		d3_s6 <= d3_s5;
		for (int k = 0; k < 4; k++)
			bx_s6[k] <= lerp(cv_s5[2*k], cv_s5[2*k+1], sx_s5);
		sy_s6 <= sy_s5;
		sz_s6 <= sz_s5;
	end

	// ---- stage 7: blend along y
	logic        v_s7, d3_s7;
	logic [15:0] by_s7 [2];
	logic [15:0] sz_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		d3_s7 <= d3_s6;
		by_s7[0] <= lerp(bx_s6[0], bx_s6[1], sy_s6);
		by_s7[1] <= lerp(bx_s6[2], bx_s6[3], sy_s6);
		sz_s7 <= sz_s6;
	end

	// ---- stage 8: blend along z (three-dimensional mode only), result register
	logic        v_s8;
	logic [15:0] r_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else v_s8 <= v_s7;
	end
	always_ff @(posedge clk) begin
		r_s8 <= d3_s7 ? lerp(by_s7[0], by_s7[1], sz_s7) : by_s7[0];
	end

	assign done = v_s8;
	assign noise_value = r_s8;

`ifndef NO_ASSERTIONS
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> ##3 done) else $error("word lost in blend stages");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> ##7 !done) else $error("word invented");
	a_mode_travels: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |=> (d3_s5 == $past(d3_s4))) else $error("mode lost");
`endif

endmodule
